// ----- src/tpgoc_pkg.sv -----
// package for the two-point gain/offset calibrator
// types, codes and constants shared by the core; no dependencies
`default_nettype none
package tpgoc_pkg;
  localparam int unsigned SPINDLE_COUNT_DEF = 4;
  localparam int unsigned POINT_COUNT_DEF   = 2;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  localparam logic [1:0] KIND_CAPTURE = 2'd0;
  localparam logic [1:0] KIND_RESET   = 2'd1;
  localparam logic [1:0] KIND_APPLY   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [1:0] ST_BAD_STATE = 2'd2;

  localparam logic [1:0] CFG_CT_RATING = 2'd0;
  localparam logic [1:0] CFG_RANGE_MIN = 2'd1;
  localparam logic [1:0] CFG_RANGE_MAX = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_CHECK, S_DIV, S_DIVFIN, S_MUL, S_OFS, S_CLR, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- src/two_point_gain_offset_calibrator_core.sv -----
// two-point gain/offset calibrator, top level
// uses tpgoc_pkg; point store and correction store are synchronous memories
// One item is in work at a time and the input stalls while it is. A capture passes
// S_RD0, S_RD1 and S_OUT; a reset adds the S_CLR pass over its point slots, and an
// apply with only pressure point 0 runs S_CHECK, S_MUL, S_OFS and S_CLR. A current
// apply and a two-point pressure apply both run a radix-2 restoring divider of 48
// steps (S_DIV, S_DIVFIN) after S_CHECK; the pressure one then goes on to S_MUL.
// An apply that fails its checks leaves S_CHECK for S_OUT, one rejected on its slope
// leaves S_DIVFIN for S_OUT. A finished result waits in the output register while
// the next item is accepted; a second finished result holds the core until the
// first is taken. No clearing pass after reset: the point store is cleared by valid
// flip-flops, the corrections by init flags.
`default_nettype none
module two_point_gain_offset_calibrator_core
  import tpgoc_pkg::*;
#(
  parameter int unsigned SPINDLE_COUNT = SPINDLE_COUNT_DEF,
  parameter int unsigned POINT_COUNT   = POINT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [2:0]         in_spindle_sel,
  input  wire logic               in_target_sel,
  input  wire logic [2:0]         in_point_index,
  input  wire logic signed [31:0] in_nominal_value,
  input  wire logic signed [31:0] in_reference_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_new_gain,
  output logic signed [31:0]      out_new_offset
);
  localparam int unsigned SW = (SPINDLE_COUNT > 1) ? $clog2(SPINDLE_COUNT) : 1;
  localparam int unsigned PW = $clog2(POINT_COUNT);
  localparam int unsigned NSLOT = SPINDLE_COUNT * 2 * POINT_COUNT;
  localparam int unsigned KW = $clog2(NSLOT);

  // configuration
  logic [30:0] ct_r;
  logic signed [31:0] rmin_r, rmax_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ct_r <= 31'd6553600;
      rmin_r <= '0;
      rmax_r <= 32'sd6553600;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CT_RATING: ct_r <= cfg_data[30:0];
        CFG_RANGE_MIN: rmin_r <= cfg_data;
        CFG_RANGE_MAX: rmax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // point memory {nominal, reference}, valid bits in flops
  logic [63:0] pmem [NSLOT];
  logic [NSLOT-1:0] pval_r, pval_nxt;
  logic pm_we;
  logic [KW-1:0] pm_wa, pm_ra;
  logic [63:0] pm_wd, pm_q_r;
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_wa] <= pm_wd;
    pm_q_r <= pmem[pm_ra];
  end

  // correction memory {pgain, poffset, cgain}, init flags give reset values
  logic [95:0] cmem [SPINDLE_COUNT];
  logic [SPINDLE_COUNT-1:0] cinit_r, cinit_nxt;
  logic cm_we;
  logic [SW-1:0] cm_a;
  logic [95:0] cm_wd, cm_q_r;
  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_a] <= cm_wd;
    cm_q_r <= cmem[cm_a];
  end

  state_t st_r, st_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic tg_r, tg_nxt;
  logic [PW-1:0] pi_r, pi_nxt, cnt_r, cnt_nxt;
  logic signed [31:0] nom_r, nom_nxt, ref_r, ref_nxt;
  logic v0_r, v0_nxt, v1_r, v1_nxt;
  logic signed [31:0] n0_r, n0_nxt, r0_r, r0_nxt;
  logic signed [31:0] pg_r, pg_nxt, po_r, po_nxt, cg_r, cg_nxt;
  logic [1:0] stat_r, stat_nxt;
  // divider: unsigned |num| (48 bits) by |den| (33 bits)
  logic [47:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic signed [31:0] gain_r, gain_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  logic [95:0] cor;
  logic [33:0] rtry;
  logic signed [32:0] dn, dr;
  logic signed [33:0] span;
  logic [33:0] adn, aspan;
  logic [38:0] adn20;
  logic signed [48:0] qs;
  logic signed [48:0] ofs;
  logic signed [31:0] gsel;
  logic in_ok, out_free;

  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7fffffff;
    else if (v < -49'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [KW-1:0] slot(input logic [SW-1:0] s, input logic t,
                                         input logic [PW-1:0] i);
    logic [31:0] k;
    k = ({29'd0, 3'(s)} * 32'd2 + {31'd0, t}) * 32'(POINT_COUNT) + {29'd0, 3'(i)};
    return k[KW-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign in_ok = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pval_r <= '0;
      cinit_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pval_r <= pval_nxt;
      cinit_r <= cinit_nxt;
      if (st_r == S_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (st_r == S_OUT && out_free) begin
      out_status <= stat_r;
      out_new_gain <= gsel;
      out_new_offset <= tg_r ? 32'sd0 : po_r;
    end
    kind_r <= kind_nxt; sp_r <= sp_nxt; tg_r <= tg_nxt; pi_r <= pi_nxt;
    cnt_r <= cnt_nxt; nom_r <= nom_nxt; ref_r <= ref_nxt;
    v0_r <= v0_nxt; v1_r <= v1_nxt; n0_r <= n0_nxt; r0_r <= r0_nxt;
    pg_r <= pg_nxt; po_r <= po_nxt; cg_r <= cg_nxt; stat_r <= stat_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
    dcnt_r <= dcnt_nxt; gain_r <= gain_nxt; prod_r <= prod_nxt;
  end

  always_comb begin
    st_nxt = st_r; kind_nxt = kind_r; sp_nxt = sp_r; tg_nxt = tg_r; pi_nxt = pi_r;
    cnt_nxt = cnt_r; nom_nxt = nom_r; ref_nxt = ref_r; v0_nxt = v0_r; v1_nxt = v1_r;
    n0_nxt = n0_r; r0_nxt = r0_r; pg_nxt = pg_r; po_nxt = po_r; cg_nxt = cg_r;
    stat_nxt = stat_r; q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    dcnt_nxt = dcnt_r; gain_nxt = gain_r; prod_nxt = prod_r;
    pval_nxt = pval_r; cinit_nxt = cinit_r;
    pm_we = 1'b0; pm_wa = slot(sp_r, tg_r, pi_r); pm_wd = {nom_r, ref_r};
    pm_ra = slot(sp_r, tg_r, '0);
    cm_we = 1'b0; cm_a = sp_r; cm_wd = {pg_r, po_r, cg_r};
    cor = cinit_r[sp_r] ? cm_q_r : {Q_ONE, 32'sd0, Q_ONE};
    dn = 33'($signed(pm_q_r[63:32])) - 33'(n0_r);
    dr = 33'($signed(pm_q_r[31:0])) - 33'(r0_r);
    span = 34'(rmax_r) - 34'(rmin_r);
    adn = dn[32] ? 34'(-35'(dn)) : 34'(dn);
    aspan = span[33] ? 34'(-35'(span)) : 34'(span);
    adn20 = 39'(adn) * 39'd20;
    rtry = {rem_r[32:0], q_r[47]} - {1'b0, den_r};
    qs = neg_r ? -49'(q_r) : 49'(q_r);
    ofs = 49'(r0_r) - 49'(prod_r >>> 16);
    gsel = tg_r ? cg_r : pg_r;
    case (st_r)
      S_IDLE: begin
        if (in_ok) begin
          kind_nxt = in_kind; tg_nxt = in_target_sel;
          sp_nxt = in_spindle_sel[SW-1:0]; pi_nxt = in_point_index[PW-1:0];
          nom_nxt = in_nominal_value; ref_nxt = in_reference_value;
          cnt_nxt = '0;
          if (32'(in_spindle_sel) >= SPINDLE_COUNT || in_kind > KIND_APPLY) begin
            // bad argument reports zero gain and offset
            stat_nxt = ST_BAD_ARG; pg_nxt = '0; po_nxt = '0; cg_nxt = '0;
            st_nxt = S_OUT;
          end else if (in_kind == KIND_CAPTURE &&
                       32'(in_point_index) >= POINT_COUNT) begin
            stat_nxt = ST_BAD_ARG; st_nxt = S_RD0;
          end else begin
            stat_nxt = ST_OK; st_nxt = S_RD0;
          end
        end
      end
      S_RD0: st_nxt = S_RD1; // memories read point 0 and corrections
      S_RD1: begin
        pg_nxt = $signed(cor[95:64]); po_nxt = $signed(cor[63:32]);
        cg_nxt = $signed(cor[31:0]);
        v0_nxt = pval_r[slot(sp_r, tg_r, '0)];
        v1_nxt = pval_r[slot(sp_r, tg_r, PW'(1))];
        n0_nxt = $signed(pm_q_r[63:32]); r0_nxt = $signed(pm_q_r[31:0]);
        if (kind_r == KIND_CAPTURE) begin
          if (stat_r == ST_OK) begin
            pm_we = 1'b1; pval_nxt[slot(sp_r, tg_r, pi_r)] = 1'b1;
          end
          st_nxt = S_OUT;
        end else if (kind_r == KIND_RESET) begin
          st_nxt = S_CLR;
        end else begin
          pm_ra = slot(sp_r, tg_r, PW'(1));
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // pm_q_r holds point 1
        dcnt_nxt = 6'd48; rem_nxt = '0;
        if (!v0_r) begin
          stat_nxt = ST_BAD_STATE; st_nxt = S_OUT;
        end else if (tg_r) begin
          if (n0_r <= 0 || 38'(n0_r) * 38'sd50 < 38'($signed({1'b0, ct_r})) ||
              r0_r <= 0) begin
            stat_nxt = ST_BAD_STATE; st_nxt = S_OUT;
          end else begin
            q_nxt = {r0_r[31:0], 16'd0}; den_nxt = {1'b0, n0_r}; neg_nxt = 1'b0;
            st_nxt = S_DIV;
          end
        end else if (v1_r) begin
          if (dn == 0 || 39'(aspan) > adn20) begin
            stat_nxt = ST_BAD_STATE; st_nxt = S_OUT;
          end else begin
            q_nxt = dr[32] ? 48'(-49'(dr)) << 16 : 48'(dr) << 16;
            den_nxt = adn[32:0]; neg_nxt = dr[32] ^ dn[32];
            st_nxt = S_DIV;
          end
        end else begin
          gain_nxt = pg_r; st_nxt = S_MUL;
        end
      end
      S_DIV: begin
        if (!rtry[33]) begin
          rem_nxt = rtry; q_nxt = {q_r[46:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[32:0], q_r[47]}; q_nxt = {q_r[46:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 6'd1;
        if (dcnt_r == 6'd1) st_nxt = S_DIVFIN;
      end
      S_DIVFIN: begin
        if (qs > 49'sd2147483647) gain_nxt = 32'sh7fffffff;
        else if (qs < -49'sd2147483648) gain_nxt = 32'sh80000000;
        else gain_nxt = qs[31:0];
        if (tg_r) begin
          cg_nxt = (qs > 49'sd2147483647) ? 32'sh7fffffff : qs[31:0];
          st_nxt = S_CLR;
        end else if (qs <= 0) begin
          stat_nxt = ST_BAD_STATE; st_nxt = S_OUT;
        end else st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = 64'(gain_r) * 64'(n0_r);
        st_nxt = S_OFS;
      end
      S_OFS: begin
        pg_nxt = gain_r; po_nxt = sat49(ofs);
        st_nxt = S_CLR;
      end
      S_CLR: begin
        // one point slot a cycle; apply also writes corrections back
        pm_wa = slot(sp_r, tg_r, cnt_r); pm_wd = '0; pm_we = 1'b1;
        pval_nxt[slot(sp_r, tg_r, cnt_r)] = 1'b0;
        if (kind_r == KIND_APPLY) begin
          cm_we = 1'b1; cinit_nxt[sp_r] = 1'b1;
        end
        cnt_nxt = cnt_r + PW'(1);
        if (32'(cnt_r) == POINT_COUNT - 1) st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- tb/sv/two_point_gain_offset_calibrator_core_tb.sv -----
// testbench for two_point_gain_offset_calibrator_core: directed and random items,
// a built-in calibration predictor and an in-order result checker; uses tpgoc_pkg
`default_nettype none
module two_point_gain_offset_calibrator_core_tb;
  import tpgoc_pkg::*;

  localparam int NSP = 4;
  localparam int NPT = 2;
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;
  localparam logic TGT_PRESSURE = 1'b0;
  localparam logic TGT_CURRENT  = 1'b1;
  localparam int Q16 = 65536;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] gain;
    logic signed [31:0] offset;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CT_RATING;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_CAPTURE;
  logic [2:0] in_spindle_sel = '0;
  logic in_target_sel = 1'b0;
  logic [2:0] in_point_index = '0;
  logic signed [31:0] in_nominal_value = '0;
  logic signed [31:0] in_reference_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_new_gain;
  logic signed [31:0] out_new_offset;

  two_point_gain_offset_calibrator_core dut (.*);

  always #10 clk = ~clk;

  // calibration state mirror
  logic [30:0]        ct_rating;
  logic signed [31:0] range_lo, range_hi;
  logic               pt_valid [NSP*2*NPT];
  logic signed [31:0] pt_nom   [NSP*2*NPT];
  logic signed [31:0] pt_ref   [NSP*2*NPT];
  logic signed [31:0] pr_gain  [NSP];
  logic signed [31:0] pr_ofs   [NSP];
  logic signed [31:0] cur_gain [NSP];

  cal_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int slot_of(int s, int t, int i);
    return (s * 2 + t) * NPT + i;
  endfunction

  function automatic void clear_slots(int s, int t);
    for (int i = 0; i < NPT; i++) begin
      pt_valid[slot_of(s, t, i)] = 1'b0;
      pt_nom[slot_of(s, t, i)] = '0;
      pt_ref[slot_of(s, t, i)] = '0;
    end
  endfunction

  function automatic logic [1:0] solve_current(int s);
    int k;
    longint n, r;
    k = slot_of(s, 1, 0);
    n = pt_nom[k];
    r = pt_ref[k];
    if (!pt_valid[k]) return ST_BAD_STATE;
    if (n <= 0 || n * 50 < longint'(ct_rating)) return ST_BAD_STATE;
    if (r <= 0) return ST_BAD_STATE;
    cur_gain[s] = clamp32((r * Q16) / n);
    return ST_OK;
  endfunction

  function automatic logic [1:0] solve_pressure(int s);
    int k0, k1;
    longint n0, r0, dn, span, g;
    k0 = slot_of(s, 0, 0);
    k1 = slot_of(s, 0, 1);
    n0 = pt_nom[k0];
    r0 = pt_ref[k0];
    if (!pt_valid[k0]) return ST_BAD_STATE;
    if (pt_valid[k1]) begin
      dn = longint'(pt_nom[k1]) - n0;
      span = longint'(range_hi) - longint'(range_lo);
      if (dn == 0) return ST_BAD_STATE;
      if ((dn < 0 ? -dn : dn) * 20 < (span < 0 ? -span : span)) return ST_BAD_STATE;
      g = clamp32(((longint'(pt_ref[k1]) - r0) * Q16) / dn);
      if (g <= 0) return ST_BAD_STATE;
    end else begin
      g = pr_gain[s];
    end
    pr_gain[s] = g[31:0];
    // arithmetic shift gives the floor of the product over 65536
    pr_ofs[s] = clamp32(r0 - ((g * n0) >>> 16));
    return ST_OK;
  endfunction

  function automatic cal_result_t predict_item(logic [1:0] kind, logic [2:0] s, logic t,
                                               logic [2:0] idx, logic signed [31:0] nom,
                                               logic signed [31:0] rf);
    cal_result_t res;
    res = '0;
    if (s >= NSP || kind == KIND_UNDEFINED) begin
      res.status = ST_BAD_ARG;
      return res;
    end
    case (kind)
      KIND_CAPTURE: begin
        if (idx >= NPT) begin
          res.status = ST_BAD_ARG;
        end else begin
          pt_valid[slot_of(s, t, idx)] = 1'b1;
          pt_nom[slot_of(s, t, idx)] = nom;
          pt_ref[slot_of(s, t, idx)] = rf;
        end
      end
      KIND_RESET: clear_slots(s, t);
      default: begin
        res.status = t ? solve_current(s) : solve_pressure(s);
        if (res.status == ST_OK) clear_slots(s, t);
      end
    endcase
    if (t) begin
      res.gain = cur_gain[s];
    end else begin
      res.gain = pr_gain[s];
      res.offset = pr_ofs[s];
    end
    return res;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [2:0] s, logic t, logic [2:0] idx,
                           logic signed [31:0] nom, logic signed [31:0] rf);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_spindle_sel <= s;
    in_target_sel <= t;
    in_point_index <= idx;
    in_nominal_value <= nom;
    in_reference_value <= rf;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_item(kind, s, t, idx, nom, rf));
    items_sent++;
  endtask

  task automatic drain();
    if (in_valid) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CT_RATING: ct_rating = value[30:0];
      CFG_RANGE_MIN: range_lo = value;
      default: range_hi = value;
    endcase
  endtask

  // item fields get a mix of small, full-width and extreme values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(33554432)) - 32'sd16777216;
    endcase
  endfunction

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cal_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item status=%0d gain=%0d offset=%0d",
                 $time, out_status, out_new_gain, out_new_offset);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          errors++;
        end
        if (out_new_gain !== exp_r.gain) begin
          $display("%0t: gain expected %0d actual %0d", $time, exp_r.gain, out_new_gain);
          errors++;
        end
        if (out_new_offset !== exp_r.offset) begin
          $display("%0t: offset expected %0d actual %0d", $time, exp_r.offset,
                   out_new_offset);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(KIND_CAPTURE, 0, TGT_PRESSURE, 0, 32'sh7fffffff, 32'sh80000000);
    send_item(KIND_UNDEFINED, 0, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_CAPTURE, 7, TGT_CURRENT, 0, 5, 5);
    send_item(KIND_CAPTURE, 0, TGT_PRESSURE, 7, 5, 5);
    send_item(KIND_RESET, 0, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_APPLY, 0, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_APPLY, 1, TGT_CURRENT, 0, 0, 0);
    // current: good point, then negative nominal, below 2 percent, bad reference
    send_item(KIND_CAPTURE, 1, TGT_CURRENT, 0, 10 * Q16, 20 * Q16);
    send_item(KIND_APPLY, 1, TGT_CURRENT, 0, 0, 0);
    send_item(KIND_CAPTURE, 1, TGT_CURRENT, 0, -Q16, 20 * Q16);
    send_item(KIND_APPLY, 1, TGT_CURRENT, 0, 0, 0);
    send_item(KIND_CAPTURE, 1, TGT_CURRENT, 0, Q16, 20 * Q16);
    send_item(KIND_APPLY, 1, TGT_CURRENT, 0, 0, 0);
    send_item(KIND_CAPTURE, 1, TGT_CURRENT, 0, 10 * Q16, 0);
    send_item(KIND_APPLY, 1, TGT_CURRENT, 0, 0, 0);
    // pressure: two-point fit, offset-only, equal nominals, falling slope
    send_item(KIND_CAPTURE, 2, TGT_PRESSURE, 0, 10 * Q16, 12 * Q16);
    send_item(KIND_CAPTURE, 2, TGT_PRESSURE, 1, 60 * Q16, 75 * Q16);
    send_item(KIND_APPLY, 2, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_CAPTURE, 2, TGT_PRESSURE, 0, -3 * Q16, 7 * Q16 + 5);
    send_item(KIND_APPLY, 2, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_CAPTURE, 3, TGT_PRESSURE, 0, 40 * Q16, 1);
    send_item(KIND_CAPTURE, 3, TGT_PRESSURE, 1, 40 * Q16, 9);
    send_item(KIND_APPLY, 3, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_CAPTURE, 3, TGT_PRESSURE, 1, 90 * Q16, -9 * Q16);
    send_item(KIND_APPLY, 3, TGT_PRESSURE, 0, 0, 0);
  endtask

  task automatic test_saturation();
    write_reg(CFG_CT_RATING, 32'h0);
    send_item(KIND_CAPTURE, 0, TGT_CURRENT, 0, 1, 32'sh7fffffff);
    send_item(KIND_APPLY, 0, TGT_CURRENT, 0, 0, 0);
    write_reg(CFG_RANGE_MAX, 32'h0);
    send_item(KIND_CAPTURE, 0, TGT_PRESSURE, 0, 0, 32'sh80000000);
    send_item(KIND_CAPTURE, 0, TGT_PRESSURE, 1, 1, 32'sh7fffffff);
    send_item(KIND_APPLY, 0, TGT_PRESSURE, 0, 0, 0);
    send_item(KIND_CAPTURE, 0, TGT_PRESSURE, 0, 32'sh80000000, 32'sh7fffffff);
    send_item(KIND_APPLY, 0, TGT_PRESSURE, 0, 0, 0);
  endtask

  // mostly capture-apply or capture-capture-apply sequences on one spindle, some noise items
  task automatic test_random(int count);
    int stop_at;
    logic [2:0] s;
    logic t;
    logic signed [31:0] n0;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        send_item(2'($urandom), 3'($urandom), 1'($urandom), 3'($urandom), pick_value(),
                  pick_value());
      end else begin
        s = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NSP - 1));
        t = 1'($urandom);
        if ($urandom_range(9) == 0) send_item(KIND_RESET, s, t, 0, 0, 0);
        n0 = pick_value();
        send_item(KIND_CAPTURE, s, t, 0, t ? {1'b0, n0[30:0]} >> $urandom_range(8) : n0,
                  pick_value());
        if (!t && $urandom_range(3) != 0)
          send_item(KIND_CAPTURE, s, t, ($urandom_range(7) == 0) ? 3'($urandom) : 3'd1,
                    n0 + $signed($urandom_range(16777216)) - 32'sd8388608, pick_value());
        send_item(KIND_APPLY, s, t, 3'($urandom), $urandom, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    test_random(30);
  endtask

  initial begin
    ct_rating = 31'd6553600;
    range_lo = 0;
    range_hi = 32'sd6553600;
    for (int k = 0; k < NSP * 2 * NPT; k++) begin
      pt_valid[k] = 1'b0;
      pt_nom[k] = '0;
      pt_ref[k] = '0;
    end
    for (int s = 0; s < NSP; s++) begin
      pr_gain[s] = Q16;
      pr_ofs[s] = '0;
      cur_gain[s] = Q16;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_saturation();
    test_backpressure();
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 66 : 0;
      rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 11 : 0;
      write_reg(CFG_CT_RATING, 32'd6553600);
      write_reg(CFG_RANGE_MIN, 32'd0);
      write_reg(CFG_RANGE_MAX, 32'd6553600);
      test_random(170);
      write_reg(CFG_CT_RATING, 32'hffffffff);
      write_reg(CFG_RANGE_MIN, 32'h80000000);
      write_reg(CFG_RANGE_MAX, 32'h7fffffff);
      test_random(170);
      write_reg(CFG_CT_RATING, 32'h0);
      write_reg(CFG_RANGE_MIN, 32'h0);
      write_reg(CFG_RANGE_MAX, 32'h0);
      test_random(170);
      write_reg(CFG_CT_RATING, $urandom_range(1 << 26));
      write_reg(CFG_RANGE_MIN, $urandom);
      write_reg(CFG_RANGE_MAX, $urandom);
      test_random(170);
    end
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("two_point_gain_offset_calibrator_core verification clean");
    end else begin
      $display("two_point_gain_offset_calibrator_core verification failed");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("two_point_gain_offset_calibrator_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire
